// ===== sv/pee_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Holds the controller state enum, result status codes, character codes and
// the command/status structs between the controller and the datapath.
package pee_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	// Character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Operand and divider widths
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DCNT_W = 6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_EMIT
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic push;       // push the digit on the input
		logic set_over;   // record overflow
		logic set_under;  // record underflow
		logic rd_start;   // latch operator, read second entry
		logic alu;        // write +, -, * result
		logic set_divz;   // record divide by zero, drop both operands
		logic div_start;  // load divider
		logic div_step;   // one restoring division step
		logic div_finish; // write signed quotient
		logic emit;       // load output register, clear stack and error
	} pee_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic op_div;
		logic err_set;
		logic under;
		logic full;
		logic den_zero;
		logic div_done;
		logic out_busy;
	} pee_sts_t;

endpackage

// ===== sv/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator.
// Joins the controller (pee_ctrl) and the datapath (pee_dp); depends on pee_pkg.
//
// Usage:
//   Input stream s_*: one ASCII character per transfer in s_tdata, s_tlast on
//   the final character of an expression. Digits push 0..9, '+', '-', '*', '/'
//   combine the two top entries, all other characters are skipped.
//   Output stream m_*: one transfer per expression, after its last character,
//   with the top value and a status (ok, underflow/empty, overflow, /0).
//   An error sticks until the end of the expression; value is zero then.
// Sequence:
//   A digit or skipped character is taken while idle. '+', '-', '*' pass a
//   read state for the registered read of the stack memory port. '/' then
//   runs the 32-step restoring divider; a zero divisor ends it in the read
//   state. The last character adds an emit state to load the output register.
// Reset clears the stack pointer, the error and the output valid.
// A stalled receiver holds the result in the output register; characters keep
// being taken until the next result needs that register.
module postfix_expression_evaluator #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] value, [33:32] status, [39:34] zero
);
	import pee_pkg::*;

	pee_cmd_t cmd;
	pee_sts_t sts;

	pee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pee_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== sv/pee_ctrl.sv =====
// Controller state machine for the postfix expression evaluator.
// Sequences digit pushes, operator reads, the iterative divide and the result.
// Depends on pee_pkg.
module pee_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  pee_pkg::pee_sts_t sts,
	output pee_pkg::pee_cmd_t cmd
);
	import pee_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        last_q;
	logic        accept;

	assign accept = in_valid && (state_q == S_IDLE);

	// State and last-mark registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= in_last;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!sts.err_set && sts.is_op && !sts.under) begin
						state_d = S_READ;
					end else if (in_last) begin
						state_d = S_EMIT;
					end
				end
			end
			S_READ: begin
				if (sts.op_div && !sts.den_zero) begin
					state_d = S_DIV;
				end else begin
					state_d = last_q ? S_EMIT : S_IDLE;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = last_q ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (accept && !sts.err_set) begin
					if (sts.is_digit) begin
						cmd.push     = !sts.full;
						cmd.set_over = sts.full;
					end else if (sts.is_op) begin
						cmd.rd_start  = !sts.under;
						cmd.set_under = sts.under;
					end
				end
			end
			S_READ: begin
				if (sts.op_div) begin
					cmd.set_divz  = sts.den_zero;
					cmd.div_start = !sts.den_zero;
				end else begin
					cmd.alu = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step   = !sts.div_done;
				cmd.div_finish = sts.div_done;
			end
			S_EMIT: begin
				cmd.emit = !sts.out_busy;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/pee_dp.sv =====
// Datapath for the postfix expression evaluator: operand stack memory with a
// top-of-stack register, adder/multiplier, iterative divider, output register.
// Depends on pee_pkg.
module pee_dp #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_code,
	input  pee_pkg::pee_cmd_t cmd,
	output pee_pkg::pee_sts_t sts,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata
);
	import pee_pkg::*;

	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Stack entries below the top; the top lives in tos_q
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [DATA_W-1:0] tos_q;
	logic [SP_W-1:0]   sp_q;
	logic [1:0]        err_q;
	logic [7:0]        op_q;

	// Divider registers
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic [DCNT_W-1:0] dcnt_q;

	// Output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [1:0]        out_status_q;

	logic [SP_W-1:0]   sp_m1;
	logic [SP_W-1:0]   sp_m2;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] digit_val;
	logic [DATA_W-1:0] alu_res;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W-1:0] mag_l;
	logic [DATA_W-1:0] mag_r;

	assign sp_m1     = sp_q - SP_W'(1);
	assign sp_m2     = sp_q - SP_W'(2);
	assign wr_addr   = sp_m1[AW-1:0];
	assign rd_addr   = sp_m2[AW-1:0];
	assign digit_val = {{(DATA_W-8){1'b0}}, char_code - CH_ZERO};

	// Decode the incoming character
	always_comb begin
		sts.is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		sts.is_op    = (char_code == CH_PLUS) || (char_code == CH_MINUS) ||
		               (char_code == CH_STAR) || (char_code == CH_SLASH);
		sts.op_div   = (op_q == CH_SLASH);
		sts.err_set  = (err_q != ST_OK);
		sts.under    = (sp_q < SP_W'(2));
		sts.full     = (sp_q == SP_W'(STACK_DEPTH));
		sts.den_zero = (tos_q == '0);
		sts.div_done = (dcnt_q == '0);
		sts.out_busy = out_valid_q && !m_tready;
	end

	// Add, subtract or multiply: left operand from memory, right from top
	always_comb begin
		unique case (op_q)
			CH_PLUS:  alu_res = rd_data_q + tos_q;
			CH_MINUS: alu_res = rd_data_q - tos_q;
			default:  alu_res = rd_data_q * tos_q;
		endcase
	end

	// Divider operand magnitudes and one restoring step
	assign mag_l  = rd_data_q[DATA_W-1] ? (DATA_W'(0) - rd_data_q) : rd_data_q;
	assign mag_r  = tos_q[DATA_W-1] ? (DATA_W'(0) - tos_q) : tos_q;
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign trial  = rem_sh - {1'b0, den_q};

	// Stack memory write: spill the old top below the new one
	always_ff @(posedge clk) begin
		if (cmd.push && (sp_q != '0)) begin
			mem[wr_addr] <= tos_q;
		end
	end

	// Stack memory read of the left operand
	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Top of stack, operator latch and divider payload
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tos_q <= digit_val;
		end else if (cmd.alu) begin
			tos_q <= alu_res;
		end else if (cmd.div_finish) begin
			tos_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
		end
		if (cmd.rd_start) begin
			op_q <= char_code;
		end
		if (cmd.div_start) begin
			quo_q <= mag_l;
			rem_q <= '0;
			den_q <= mag_r;
			neg_q <= rd_data_q[DATA_W-1] ^ tos_q[DATA_W-1];
		end else if (cmd.div_step) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
			end
			quo_q <= {quo_q[DATA_W-2:0], !trial[DATA_W]};
		end
		if (cmd.emit) begin
			if (err_q != ST_OK) begin
				out_value_q  <= '0;
				out_status_q <= err_q;
			end else if (sp_q == '0) begin
				out_value_q  <= '0;
				out_status_q <= ST_UNDER;
			end else begin
				out_value_q  <= tos_q;
				out_status_q <= ST_OK;
			end
		end
	end

	// Stack pointer, sticky error, divide counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			err_q       <= ST_OK;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.emit) begin
				sp_q  <= '0;
				err_q <= ST_OK;
			end else if (cmd.push) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (cmd.alu || cmd.div_finish) begin
				sp_q <= sp_m1;
			end else if (cmd.set_divz) begin
				sp_q  <= sp_m2;
				err_q <= ST_DIVZ;
			end else if (cmd.set_over) begin
				err_q <= ST_OVER;
			end else if (cmd.set_under) begin
				err_q <= ST_UNDER;
			end else begin
				sp_q <= sp_q;
			end
			if (cmd.div_start) begin
				dcnt_q <= DCNT_W'(DATA_W);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_value_q};

endmodule

// ===== sv/pee_chk.sv =====
// Port-level checker for the postfix expression evaluator, bound to the top.
// Watches the input and output streams only; no package dependency.
module pee_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Error status carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:32] != 2'd0) |-> (m_tdata[31:0] == 32'd0))
		else $error("nonzero value with error status");

	// Padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:34] == 6'd0))
		else $error("padding bits set");

	// Drop ready after the last character while the result is formed
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("ready right after last transfer");

endmodule

bind postfix_expression_evaluator pee_chk u_pee_chk (.*);
